// ===== src/nplk_pkg.sv =====
`default_nettype none

package nplk_pkg;

  // Store geometry and field widths
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int LABEL_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 2;
  localparam int ENTRY_BITS = 3 * COORD_BITS + LABEL_BITS;
  localparam int OP_BITS    = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS  = 3 * COORD_BITS + LABEL_BITS;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int IN_W     = 8 * IN_BYTES;
  localparam int OUT_BITS  = 1 + IDX_BITS + LABEL_BITS + DIST_BITS + 1;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_W     = 8 * OUT_BYTES;
  localparam int USER_W    = 8;

  // Operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RES_LOAD,
    ST_RES_QUERY
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load;
    logic query;
    logic issue;
    logic publish;
    logic publish_query;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic last_addr;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/nearest_point_label_lookup_core.sv =====
// Clear gives no result; loads and empty-store queries are answered via the result states.
// Query scans the stored points one per cycle through the store read port and a three-stage
// square and sum pipeline; after the drain the result state publishes into the output register.
// One request is in work at a time; the next is taken once the result is registered, even while
// it waits; a result state holds while the output register is still occupied.
// Synchronous reset empties the store and idles the controller; point memory is not cleared.
`default_nettype none

module nearest_point_label_lookup_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // coord_x, coord_y, coord_z, point_label
  input  wire logic [nplk_pkg::IN_W-1:0]     s_tdata,
  // operation, zero padding
  input  wire logic [nplk_pkg::USER_W-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // found, nearest_index, nearest_label, nearest_distance_sq, load_overflow, zero padding
  output logic [nplk_pkg::OUT_W-1:0]         m_tdata
);

  nplk_pkg::cmd_t    cmd;
  nplk_pkg::status_t status;

  nplk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_op    (s_tuser[nplk_pkg::OP_BITS-1:0]),
    .status    (status),
    .req_ready (s_tready),
    .cmd       (cmd)
  );

  nplk_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_data  (s_tdata[nplk_pkg::IN_BITS-1:0]),
    .out_ready (m_tready),
    .status    (status),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== src/nplk_ctrl.sv =====
`default_nettype none

module nplk_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire logic [nplk_pkg::OP_BITS-1:0]  req_op,
  input  wire nplk_pkg::status_t             status,
  output logic                               req_ready,
  output nplk_pkg::cmd_t                     cmd
);

  nplk_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nplk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      nplk_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_op)
            nplk_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            nplk_pkg::OP_LOAD: begin
              cmd.load   = 1'b1;
              state_next = nplk_pkg::ST_RES_LOAD;
            end
            nplk_pkg::OP_QUERY: begin
              cmd.query  = 1'b1;
              state_next = status.empty ? nplk_pkg::ST_RES_QUERY : nplk_pkg::ST_SCAN;
            end
            default: begin
              // unused code: drop the request
            end
          endcase
        end
      end
      nplk_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_addr) begin
          state_next = nplk_pkg::ST_DRAIN;
        end
      end
      nplk_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = nplk_pkg::ST_RES_QUERY;
        end
      end
      nplk_pkg::ST_RES_LOAD: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = nplk_pkg::ST_IDLE;
        end
      end
      nplk_pkg::ST_RES_QUERY: begin
        if (status.out_free) begin
          cmd.publish       = 1'b1;
          cmd.publish_query = 1'b1;
          state_next        = nplk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nplk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/nplk_datapath.sv =====
`default_nettype none

module nplk_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire nplk_pkg::cmd_t                cmd,
  input  wire logic [nplk_pkg::IN_BITS-1:0]  req_data,
  input  wire logic                          out_ready,
  output nplk_pkg::status_t                  status,
  output logic                               out_valid,
  output logic [nplk_pkg::OUT_W-1:0]         out_data
);

  localparam int CB = nplk_pkg::COORD_BITS;
  localparam int LB = nplk_pkg::LABEL_BITS;
  localparam int IB = nplk_pkg::IDX_BITS;
  localparam int NB = nplk_pkg::CNT_BITS;
  localparam int DB = nplk_pkg::DIFF_BITS;
  localparam int SB = nplk_pkg::SQ_BITS;
  localparam int TB = nplk_pkg::DIST_BITS;

  // Point store: x, y, z, label per entry
  logic [nplk_pkg::ENTRY_BITS-1:0] mem [nplk_pkg::MAX_POINTS];
  logic [nplk_pkg::ENTRY_BITS-1:0] rd_data;

  logic [NB-1:0] point_count;
  logic [IB-1:0] scan_addr;
  logic          full;
  logic          overflow;

  logic signed [CB-1:0] qx, qy, qz;

  // Pipeline stage registers
  logic          v1, v2, v3;
  logic [IB-1:0] idx1, idx2, idx3;
  logic [LB-1:0] lbl2, lbl3;
  logic [SB-1:0] sqx, sqy, sqz;
  logic [TB-1:0] dist3;

  // Running best
  logic          have;
  logic [IB-1:0] best_idx;
  logic [LB-1:0] best_lbl;
  logic [TB-1:0] best_dist;

  logic signed [DB-1:0]   dx, dy, dz;
  logic signed [2*DB-1:0] px, py, pz;
  logic signed [CB-1:0]   sx, sy, sz;

  logic [nplk_pkg::OUT_W-1:0] out_word;

  assign full = (point_count == NB'(nplk_pkg::MAX_POINTS));

  // Write the store on an accepted load
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[point_count[IB-1:0]] <= req_data;
    end
  end

  // Registered store read during the scan
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[scan_addr];
    end
  end

  // Point count, scan address and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      scan_addr   <= '0;
      overflow    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        point_count <= '0;
      end
      if (cmd.load) begin
        overflow <= full;
        if (!full) begin
          point_count <= point_count + NB'(1);
        end
      end
      if (cmd.query) begin
        scan_addr <= '0;
      end else if (cmd.issue) begin
        scan_addr <= scan_addr + IB'(1);
      end
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      qx <= req_data[CB-1:0];
      qy <= req_data[2*CB-1:CB];
      qz <= req_data[3*CB-1:2*CB];
    end
  end

  // Differences and squares
  assign sx = rd_data[CB-1:0];
  assign sy = rd_data[2*CB-1:CB];
  assign sz = rd_data[3*CB-1:2*CB];
  assign dx = DB'(qx) - DB'(sx);
  assign dy = DB'(qy) - DB'(sy);
  assign dz = DB'(qz) - DB'(sz);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage payloads: square, then sum
  always_ff @(posedge clk) begin
    idx1  <= scan_addr;
    idx2  <= idx1;
    lbl2  <= rd_data[nplk_pkg::ENTRY_BITS-1:3*CB];
    sqx   <= px[SB-1:0];
    sqy   <= py[SB-1:0];
    sqz   <= pz[SB-1:0];
    idx3  <= idx2;
    lbl3  <= lbl2;
    dist3 <= TB'(sqx) + TB'(sqy) + TB'(sqz);
  end

  // Keep the first strict minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.query) begin
      have <= 1'b0;
    end else if (v3 && (!have || dist3 < best_dist)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && (!have || dist3 < best_dist)) begin
      best_dist <= dist3;
      best_idx  <= idx3;
      best_lbl  <= lbl3;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Assemble the result word
  always_comb begin
    out_word = '0;
    if (cmd.publish_query) begin
      if (have) begin
        out_word[0]                = 1'b1;
        out_word[IB:1]             = best_idx;
        out_word[IB+LB:IB+1]       = best_lbl;
        out_word[IB+LB+TB:IB+LB+1] = best_dist;
      end
    end else begin
      out_word[IB+LB+TB+1] = overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= out_word;
    end
  end

  // Status back to the controller
  assign status.empty     = (point_count == '0);
  assign status.last_addr = ({1'b0, scan_addr} == point_count - NB'(1));
  assign status.pipe_busy = v1 | v2 | v3;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam logic [nplk_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 580;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT_FIRST = 20;
  localparam int HOLD_AT_SECOND = 1300;
  localparam int STALL_LIMIT = 4000;

  // m_tdata bit offsets
  localparam int IDX_LO = 1;
  localparam int LBL_LO = IDX_LO + nplk_pkg::IDX_BITS;
  localparam int DST_LO = LBL_LO + nplk_pkg::LABEL_BITS;
  localparam int OVF_AT = DST_LO + nplk_pkg::DIST_BITS;

  typedef logic [nplk_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [nplk_pkg::LABEL_BITS-1:0] label_t;
  typedef logic [nplk_pkg::OP_BITS-1:0]    op_code_t;

  typedef struct {
    logic [nplk_pkg::OP_BITS-1:0]           op;
    logic signed [nplk_pkg::COORD_BITS-1:0] x;
    logic signed [nplk_pkg::COORD_BITS-1:0] y;
    logic signed [nplk_pkg::COORD_BITS-1:0] z;
    logic [nplk_pkg::LABEL_BITS-1:0]        label;
    bit                                     drain_first;
  } lookup_req_t;

  typedef struct {
    logic                            found;
    logic [nplk_pkg::IDX_BITS-1:0]   index;
    logic [nplk_pkg::LABEL_BITS-1:0] label;
    logic [nplk_pkg::DIST_BITS-1:0]  dist_sq;
    logic                            overflow;
  } nearest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [nplk_pkg::IN_W-1:0] s_tdata = '0;
  logic [nplk_pkg::USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [nplk_pkg::OUT_W-1:0] m_tdata;

  nearest_point_label_lookup_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the point store
  logic signed [nplk_pkg::COORD_BITS-1:0] kept_x [nplk_pkg::MAX_POINTS];
  logic signed [nplk_pkg::COORD_BITS-1:0] kept_y [nplk_pkg::MAX_POINTS];
  logic signed [nplk_pkg::COORD_BITS-1:0] kept_z [nplk_pkg::MAX_POINTS];
  logic [nplk_pkg::LABEL_BITS-1:0]        kept_label [nplk_pkg::MAX_POINTS];
  int                                     kept_count = 0;

  lookup_req_t lookup_backlog[$];
  nearest_t    pending_matches[$];

  int error_count = 0;
  int results_seen = 0;
  int n_load = 0, n_query = 0, n_clear = 0, n_unused = 0, n_dropped = 0;

  // Update the shadow store and queue the result this request should give
  function automatic void apply_request(lookup_req_t r);
    nearest_t m;
    longint dx, dy, dz, d, best;
    m = '{default: '0};
    best = 0;
    case (r.op)
      nplk_pkg::OP_CLEAR: kept_count = 0;
      nplk_pkg::OP_LOAD: begin
        if (kept_count < nplk_pkg::MAX_POINTS) begin
          kept_x[kept_count] = r.x;
          kept_y[kept_count] = r.y;
          kept_z[kept_count] = r.z;
          kept_label[kept_count] = r.label;
          kept_count++;
        end else begin
          m.overflow = 1'b1;
        end
        pending_matches.push_back(m);
      end
      nplk_pkg::OP_QUERY: begin
        for (int i = 0; i < kept_count; i++) begin
          dx = longint'(r.x) - longint'(kept_x[i]);
          dy = longint'(r.y) - longint'(kept_y[i]);
          dz = longint'(r.z) - longint'(kept_z[i]);
          d = dx * dx + dy * dy + dz * dz;
          // strict less-than keeps the lowest index on ties
          if (!m.found || d < best) begin
            m.found = 1'b1;
            m.index = i[nplk_pkg::IDX_BITS-1:0];
            m.label = kept_label[i];
            best = d;
          end
        end
        m.dist_sq = best[nplk_pkg::DIST_BITS-1:0];
        pending_matches.push_back(m);
      end
      default: ;
    endcase
  endfunction

  function automatic nearest_t unpack_result(logic [nplk_pkg::OUT_W-1:0] w);
    nearest_t m;
    m.found = w[0];
    m.index = w[IDX_LO +: nplk_pkg::IDX_BITS];
    m.label = w[LBL_LO +: nplk_pkg::LABEL_BITS];
    m.dist_sq = w[DST_LO +: nplk_pkg::DIST_BITS];
    m.overflow = w[OVF_AT];
    return m;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Wait cycles before the next request; occasionally flip into a no-wait burst
  function automatic int pick_wait(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic coord_t rand_coord(int style);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 16) - 8);
      2: return coord_t'($urandom_range(0, 4096) - 2048);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic add_req(logic [nplk_pkg::OP_BITS-1:0] op, coord_t x, coord_t y, coord_t z,
                         label_t label, bit drain_first);
    lookup_req_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.z = z;
    r.label = label;
    r.drain_first = drain_first;
    lookup_backlog.push_back(r);
  endtask

  // Request driver
  lookup_req_t in_flight;
  int send_gap = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_request(in_flight);
        case (in_flight.op)
          nplk_pkg::OP_CLEAR: n_clear++;
          nplk_pkg::OP_LOAD:  n_load++;
          nplk_pkg::OP_QUERY: n_query++;
          default:            n_unused++;
        endcase
        send_gap = pick_wait(send_burst);
      end
      // hold the offered request until taken
      if (s_tvalid && !s_tready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (lookup_backlog.size() != 0 &&
                   (!lookup_backlog[0].drain_first || pending_matches.size() == 0)) begin
        in_flight = lookup_backlog.pop_front();
        s_tdata <= {in_flight.label, in_flight.z, in_flight.y, in_flight.x};
        s_tuser <= {{(nplk_pkg::USER_W-nplk_pkg::OP_BITS){1'b0}}, in_flight.op};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls
  int sink_wait = 0;
  bit sink_burst = 1'b0;
  nearest_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = unpack_result(m_tdata);
        if (pending_matches.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
        end else begin
          want = pending_matches.pop_front();
          check_field("found", want.found, got.found);
          check_field("nearest_index", want.index, got.index);
          check_field("nearest_label", want.label, got.label);
          check_field("nearest_distance_sq", want.dist_sq, got.dist_sq);
          check_field("load_overflow", want.overflow, got.overflow);
        end
        if (got.overflow) n_dropped++;
        results_seen++;
        if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
          sink_wait = LONG_HOLD;
        else
          sink_wait = pick_wait(sink_burst);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      m_tready <= (sink_wait == 0);
    end
  end

  // Abort when nothing moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [3*nplk_pkg::COORD_BITS-1:0] seq_pts[$];
    logic [3*nplk_pkg::COORD_BITS-1:0] p;
    coord_t x, y, z;
    logic [nplk_pkg::OP_BITS-1:0] op;
    int random_items;
    int style;

    // Directed: empty store, extremes, ties, unused code
    add_req(nplk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h1234, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 16'ha5a5, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h7fff, 16'h8000, 16'h7ff0, 16'h5a5a, 1'b0);
    add_req(nplk_pkg::OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    add_req(nplk_pkg::OP_QUERY, 16'h0100, 16'h0100, 16'h0100, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8001, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h0100, 16'h0000, 16'h0000, 16'h0001, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'hff00, 16'h0000, 16'h0000, 16'h0002, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h0000, 16'h0100, 16'h0000, 16'h0003, 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h0100, 16'h0000, 16'h0000, 16'h0004, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(OP_UNUSED, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 1'b1);
    add_req(nplk_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 1'b0);

    // Fill the store to the top, overrun it, query the full store
    add_req(nplk_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    for (int i = 0; i < nplk_pkg::MAX_POINTS - 1; i++)
      add_req(nplk_pkg::OP_LOAD, rand_coord(i % 4), rand_coord(i % 4), rand_coord(i % 4),
              label_t'($urandom), 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h0064, 16'hff9c, 16'h0005, 16'hbeef, 1'b0);
    repeat (3) add_req(nplk_pkg::OP_LOAD, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), label_t'($urandom), 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h0064, 16'hff9c, 16'h0005, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
            label_t'($urandom), 1'b0);
    add_req(nplk_pkg::OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_req(nplk_pkg::OP_QUERY, rand_coord(1), rand_coord(1), rand_coord(1),
            label_t'($urandom), 1'b0);
    add_req(nplk_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);

    // Random: mostly clear, a batch of loads, then queries; some noise
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        style = $urandom_range(0, 3);
        seq_pts.delete();
        if ($urandom_range(0, 9) < 7) begin
          add_req(nplk_pkg::OP_CLEAR, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), label_t'($urandom), $urandom_range(0, 19) == 0);
          random_items++;
        end
        repeat ($urandom_range(1, 24)) begin
          x = rand_coord(style);
          y = rand_coord(style);
          z = rand_coord(style);
          seq_pts.push_back({z, y, x});
          add_req(nplk_pkg::OP_LOAD, x, y, z, label_t'($urandom), 1'b0);
          random_items++;
        end
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            // land near a point of this batch
            p = seq_pts[$urandom_range(0, seq_pts.size() - 1)];
            x = coord_t'(p[0 +: nplk_pkg::COORD_BITS] + $urandom_range(0, 4) - 2);
            y = coord_t'(p[nplk_pkg::COORD_BITS +: nplk_pkg::COORD_BITS]
                         + $urandom_range(0, 4) - 2);
            z = coord_t'(p[2*nplk_pkg::COORD_BITS +: nplk_pkg::COORD_BITS]
                         + $urandom_range(0, 4) - 2);
          end else begin
            x = rand_coord(style);
            y = rand_coord(style);
            z = rand_coord(style);
          end
          add_req(nplk_pkg::OP_QUERY, x, y, z, label_t'($urandom), 1'b0);
          random_items++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = op_code_t'($urandom_range(0, 3));
          add_req(op, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  label_t'($urandom), 1'b0);
          if (op != OP_UNUSED) random_items++;
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every result back, then a quiet tail
    while (lookup_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d loads (%0d dropped on a full store), %0d queries, %0d clears, %0d unused",
             n_load, n_dropped, n_query, n_clear, n_unused);
    $display("Checked %0d results, %0d mismatches", results_seen, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/nplk_pkg.sv
src/nplk_ctrl.sv
src/nplk_datapath.sv
src/nearest_point_label_lookup_core.sv
bench/tb_top.sv
